>>> rtl/clfw_pkg.sv
`default_nettype none
package clfw_pkg;

	localparam int IDX_W     = 16;
	localparam int COORD_W   = 32;
	localparam int EDGE_W    = COORD_W + 1;
	localparam int OPND_W    = EDGE_W + 1;
	localparam int PROD_W    = 2 * OPND_W;
	localparam int ACC_W     = 134;
	localparam int DOT_W     = 68;
	localparam int CMAG_W    = 66;
	localparam int HALF_W    = CMAG_W / 2;
	localparam int ROOT_W    = ACC_W / 2;
	localparam int REM_W     = ROOT_W + 3;
	localparam int FRAC_SH   = 15;
	localparam int DVD_W     = DOT_W + FRAC_SH;
	localparam int W_W       = 32;
	localparam int QDEPTH    = 2;
	localparam int QPTR_W    = $clog2(QDEPTH);
	localparam int QCNT_W    = $clog2(QDEPTH + 1);
	localparam int ENTRIES   = 12;
	localparam int CNT_W     = 4;
	localparam int STEP_W    = 7;
	localparam int MUL_LAST  = 18;
	localparam int SQRT_LAST = ROOT_W - 1;
	localparam int DIV_LAST  = DVD_W - 1;

	typedef logic signed [EDGE_W-1:0] edge_t;

	typedef struct packed {
		edge_t x;
		edge_t y;
		edge_t z;
	} vec_t;

	typedef struct packed {
		vec_t e1;
		vec_t e2;
	} corner_t;

	typedef struct packed {
		logic [IDX_W-1:0] vertex_a_index;
		logic [IDX_W-1:0] vertex_b_index;
		logic [IDX_W-1:0] vertex_c_index;
		logic signed [COORD_W-1:0] a_x;
		logic signed [COORD_W-1:0] a_y;
		logic signed [COORD_W-1:0] a_z;
		logic signed [COORD_W-1:0] b_x;
		logic signed [COORD_W-1:0] b_y;
		logic signed [COORD_W-1:0] b_z;
		logic signed [COORD_W-1:0] c_x;
		logic signed [COORD_W-1:0] c_y;
		logic signed [COORD_W-1:0] c_z;
	} face_t;

	typedef struct packed {
		logic [IDX_W-1:0] row_index;
		logic [IDX_W-1:0] column_index;
		logic signed [W_W-1:0] entry_value;
		logic last_entry;
	} entry_t;

	typedef struct packed {
		logic [IDX_W-1:0] ia;
		logic [IDX_W-1:0] ib;
		logic [IDX_W-1:0] ic;
		corner_t [2:0] corner;
	} pkt_t;

	typedef struct packed {
		logic [IDX_W-1:0] ia;
		logic [IDX_W-1:0] ib;
		logic [IDX_W-1:0] ic;
		logic [2:0][W_W-1:0] w;
	} wpkt_t;

	function automatic edge_t edge_diff(input logic signed [COORD_W-1:0] to_p,
			input logic signed [COORD_W-1:0] from_p);
		return EDGE_W'(to_p) - EDGE_W'(from_p);
	endfunction

	function automatic vec_t vec_diff(input logic signed [COORD_W-1:0] tx,
			input logic signed [COORD_W-1:0] ty, input logic signed [COORD_W-1:0] tz,
			input logic signed [COORD_W-1:0] fx, input logic signed [COORD_W-1:0] fy,
			input logic signed [COORD_W-1:0] fz);
		vec_t v;
		v.x = edge_diff(tx, fx);
		v.y = edge_diff(ty, fy);
		v.z = edge_diff(tz, fz);
		return v;
	endfunction

endpackage
`default_nettype wire

>>> rtl/clfw_face_if.sv
`default_nettype none
interface clfw_face_if;
	logic valid;
	logic ready;
	clfw_pkg::face_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

>>> rtl/clfw_entry_if.sv
`default_nettype none
interface clfw_entry_if;
	logic valid;
	logic ready;
	clfw_pkg::entry_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

>>> rtl/clfw_front.sv
`default_nettype none
module clfw_front (
	input  logic clk,
	input  logic arst_n,
	clfw_face_if.sink face,
	output logic out_valid,
	input  logic out_ready,
	output clfw_pkg::pkt_t out_pkt
);
	clfw_pkg::pkt_t mem_q [clfw_pkg::QDEPTH];
	logic [clfw_pkg::QPTR_W-1:0] wr_ptr_q;
	logic [clfw_pkg::QPTR_W-1:0] rd_ptr_q;
	logic [clfw_pkg::QCNT_W-1:0] cnt_q;
	clfw_pkg::pkt_t pkt;
	logic push;
	logic pop;

	// Each corner gets its edge vectors e1 and e2, both leaving that corner.
	always_comb begin
		pkt.ia = face.data.vertex_a_index;
		pkt.ib = face.data.vertex_b_index;
		pkt.ic = face.data.vertex_c_index;
		pkt.corner[0].e1 = clfw_pkg::vec_diff(face.data.b_x, face.data.b_y, face.data.b_z,
			face.data.a_x, face.data.a_y, face.data.a_z);
		pkt.corner[0].e2 = clfw_pkg::vec_diff(face.data.c_x, face.data.c_y, face.data.c_z,
			face.data.a_x, face.data.a_y, face.data.a_z);
		pkt.corner[1].e1 = clfw_pkg::vec_diff(face.data.c_x, face.data.c_y, face.data.c_z,
			face.data.b_x, face.data.b_y, face.data.b_z);
		pkt.corner[1].e2 = clfw_pkg::vec_diff(face.data.a_x, face.data.a_y, face.data.a_z,
			face.data.b_x, face.data.b_y, face.data.b_z);
		pkt.corner[2].e1 = clfw_pkg::vec_diff(face.data.a_x, face.data.a_y, face.data.a_z,
			face.data.c_x, face.data.c_y, face.data.c_z);
		pkt.corner[2].e2 = clfw_pkg::vec_diff(face.data.b_x, face.data.b_y, face.data.b_z,
			face.data.c_x, face.data.c_y, face.data.c_z);
	end

	assign face.ready = (cnt_q != clfw_pkg::QCNT_W'(clfw_pkg::QDEPTH));
	assign out_valid  = (cnt_q != '0);
	assign out_pkt    = mem_q[rd_ptr_q];
	assign push       = face.valid && face.ready;
	assign pop        = out_valid && out_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= pkt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= clfw_pkg::QCNT_W'(clfw_pkg::QDEPTH))
		else $error("front queue count out of range");
	a_ptr_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == '0) |-> (wr_ptr_q == rd_ptr_q))
		else $error("empty queue with pointers apart");
	a_full_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!face.ready && !out_ready) |=> $stable(cnt_q))
		else $error("queue count moved while full and stalled");

endmodule
`default_nettype wire

>>> rtl/clfw_calc.sv
`default_nettype none
module clfw_calc (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  clfw_pkg::pkt_t in_pkt,
	output logic out_valid,
	input  logic out_ready,
	output clfw_pkg::wpkt_t out_wpkt
);
	typedef enum logic [2:0] {S_IDLE, S_MUL, S_SQRT, S_DIV, S_FIN, S_OUT} state_t;
	typedef enum logic [2:0] {DST_NONE, DST_DOT, DST_CX, DST_CY, DST_CZ} dst_t;
	typedef enum logic [1:0] {SH_0, SH_MID, SH_TOP} sh_t;

	typedef struct packed {
		logic vld;
		logic sub;
		logic clr;
		sh_t sh;
		dst_t dst;
	} mop_t;

	state_t state_q;
	clfw_pkg::pkt_t pkt_q;
	logic [1:0] corner_q;
	logic [clfw_pkg::STEP_W-1:0] step_q;
	logic [2:0][clfw_pkg::W_W-1:0] w_q;

	logic signed [clfw_pkg::OPND_W-1:0] op_a;
	logic signed [clfw_pkg::OPND_W-1:0] op_b;
	mop_t mop;
	logic signed [clfw_pkg::PROD_W-1:0] prod_s1;
	mop_t mop_s1;

	logic signed [clfw_pkg::ACC_W-1:0] acc_q;
	logic signed [clfw_pkg::ACC_W-1:0] term;
	logic signed [clfw_pkg::ACC_W-1:0] acc_next;
	logic signed [clfw_pkg::DOT_W-1:0] dot_q;
	logic [clfw_pkg::CMAG_W-1:0] cx_q;
	logic [clfw_pkg::CMAG_W-1:0] cy_q;
	logic [clfw_pkg::CMAG_W-1:0] cz_q;
	logic [clfw_pkg::CMAG_W:0] c_raw;
	logic [clfw_pkg::CMAG_W:0] c_mag;

	logic [clfw_pkg::REM_W-1:0] rem_q;
	logic [clfw_pkg::ROOT_W-1:0] root_q;
	logic [clfw_pkg::REM_W-1:0] sq_r;
	logic [clfw_pkg::REM_W-1:0] sq_t;
	logic sq_ge;

	logic [clfw_pkg::DVD_W-1:0] dvd_q;
	logic [clfw_pkg::W_W-1:0] q_q;
	logic ovf_q;
	logic [clfw_pkg::ROOT_W-1:0] div_d;
	logic [clfw_pkg::ROOT_W+1:0] dv_r;
	logic dv_ge;
	logic [clfw_pkg::DOT_W-1:0] dot_mag;

	logic neg;
	logic [clfw_pkg::W_W-1:0] limit;
	logic [clfw_pkg::W_W-1:0] wmag;
	logic [clfw_pkg::W_W-1:0] wval;

	clfw_pkg::corner_t cur;

	assign cur = pkt_q.corner[corner_q];

	function automatic logic signed [clfw_pkg::OPND_W-1:0] OPND_SX(input clfw_pkg::edge_t e);
		return clfw_pkg::OPND_W'(e);
	endfunction

	function automatic logic signed [clfw_pkg::OPND_W-1:0] HI(
			input logic [clfw_pkg::CMAG_W-1:0] m);
		return {1'b0, m[clfw_pkg::CMAG_W-1:clfw_pkg::HALF_W]};
	endfunction

	function automatic logic signed [clfw_pkg::OPND_W-1:0] LO(
			input logic [clfw_pkg::CMAG_W-1:0] m);
		return {1'b0, m[clfw_pkg::HALF_W-1:0]};
	endfunction

	// Micro-program: dot product, cross product, then the squared cross length
	// from 33-bit halves of each cross component's magnitude.
	always_comb begin
		op_a = '0;
		op_b = '0;
		mop  = '{vld: 1'b0, sub: 1'b0, clr: 1'b0, sh: SH_0, dst: DST_NONE};
		if (state_q == S_MUL) begin
			mop.vld = 1'b1;
			unique case (step_q)
				7'd0: begin op_a = OPND_SX(cur.e1.x); op_b = OPND_SX(cur.e2.x); mop.clr = 1'b1; end
				7'd1: begin op_a = OPND_SX(cur.e1.y); op_b = OPND_SX(cur.e2.y); end
				7'd2: begin
					op_a = OPND_SX(cur.e1.z); op_b = OPND_SX(cur.e2.z); mop.dst = DST_DOT;
				end
				7'd3: begin op_a = OPND_SX(cur.e1.y); op_b = OPND_SX(cur.e2.z); mop.clr = 1'b1; end
				7'd4: begin
					op_a = OPND_SX(cur.e1.z); op_b = OPND_SX(cur.e2.y);
					mop.sub = 1'b1; mop.dst = DST_CX;
				end
				7'd5: begin op_a = OPND_SX(cur.e1.z); op_b = OPND_SX(cur.e2.x); mop.clr = 1'b1; end
				7'd6: begin
					op_a = OPND_SX(cur.e1.x); op_b = OPND_SX(cur.e2.z);
					mop.sub = 1'b1; mop.dst = DST_CY;
				end
				7'd7: begin op_a = OPND_SX(cur.e1.x); op_b = OPND_SX(cur.e2.y); mop.clr = 1'b1; end
				7'd8: begin
					op_a = OPND_SX(cur.e1.y); op_b = OPND_SX(cur.e2.x);
					mop.sub = 1'b1; mop.dst = DST_CZ;
				end
				7'd9: begin
					op_a = HI(cx_q); op_b = HI(cx_q); mop.sh = SH_TOP; mop.clr = 1'b1;
				end
				7'd10: begin op_a = HI(cx_q); op_b = LO(cx_q); mop.sh = SH_MID; end
				7'd11: begin op_a = LO(cx_q); op_b = LO(cx_q); end
				7'd12: begin op_a = HI(cy_q); op_b = HI(cy_q); mop.sh = SH_TOP; end
				7'd13: begin op_a = HI(cy_q); op_b = LO(cy_q); mop.sh = SH_MID; end
				7'd14: begin op_a = LO(cy_q); op_b = LO(cy_q); end
				7'd15: begin op_a = HI(cz_q); op_b = HI(cz_q); mop.sh = SH_TOP; end
				7'd16: begin op_a = HI(cz_q); op_b = LO(cz_q); mop.sh = SH_MID; end
				7'd17: begin op_a = LO(cz_q); op_b = LO(cz_q); end
				default: mop.vld = 1'b0;
			endcase
		end
	end

	// The cross term hi*lo is counted twice, hence the shift by one more bit.
	always_comb begin
		unique case (mop_s1.sh)
			SH_TOP:  term = clfw_pkg::ACC_W'(prod_s1) <<< (2 * clfw_pkg::HALF_W);
			SH_MID:  term = clfw_pkg::ACC_W'(prod_s1) <<< (clfw_pkg::HALF_W + 1);
			default: term = clfw_pkg::ACC_W'(prod_s1);
		endcase
		acc_next = (mop_s1.clr ? '0 : acc_q) + (mop_s1.sub ? -term : term);
		c_raw = acc_next[clfw_pkg::CMAG_W:0];
		c_mag = c_raw[clfw_pkg::CMAG_W] ? (~c_raw + 1'b1) : c_raw;
	end

	always_comb begin
		sq_r  = {rem_q[clfw_pkg::REM_W-3:0], acc_q[clfw_pkg::ACC_W-1:clfw_pkg::ACC_W-2]};
		sq_t  = {1'b0, root_q, 2'b01};
		sq_ge = (sq_r >= sq_t);
		div_d = (root_q == '0) ? clfw_pkg::ROOT_W'(1) : root_q;
		dv_r  = {rem_q[clfw_pkg::ROOT_W:0], dvd_q[clfw_pkg::DVD_W-1]};
		dv_ge = (dv_r >= {2'b00, div_d});
		dot_mag = dot_q[clfw_pkg::DOT_W-1] ? (~dot_q + 1'b1) : dot_q;
		neg   = dot_q[clfw_pkg::DOT_W-1];
		limit = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
		wmag  = (ovf_q || (q_q > limit)) ? limit : q_q;
		wval  = neg ? (~wmag + 1'b1) : wmag;
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = (state_q == S_OUT);
	assign out_wpkt  = '{ia: pkt_q.ia, ib: pkt_q.ib, ic: pkt_q.ic, w: w_q};

	always_ff @(posedge clk) begin
		prod_s1 <= op_a * op_b;
		if (mop_s1.vld) begin
			acc_q <= acc_next;
			unique case (mop_s1.dst)
				DST_DOT: dot_q <= acc_next[clfw_pkg::DOT_W-1:0];
				DST_CX:  cx_q  <= c_mag[clfw_pkg::CMAG_W-1:0];
				DST_CY:  cy_q  <= c_mag[clfw_pkg::CMAG_W-1:0];
				DST_CZ:  cz_q  <= c_mag[clfw_pkg::CMAG_W-1:0];
				default: ;
			endcase
		end else if (state_q == S_SQRT) begin
			acc_q <= {acc_q[clfw_pkg::ACC_W-3:0], 2'b00};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			corner_q <= '0;
			step_q   <= '0;
			mop_s1   <= '{vld: 1'b0, sub: 1'b0, clr: 1'b0, sh: SH_0, dst: DST_NONE};
		end else begin
			mop_s1 <= mop;
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						pkt_q    <= in_pkt;
						corner_q <= '0;
						step_q   <= '0;
						state_q  <= S_MUL;
					end
				end
				S_MUL: begin
					if (step_q == clfw_pkg::STEP_W'(clfw_pkg::MUL_LAST)) begin
						step_q  <= '0;
						rem_q   <= '0;
						root_q  <= '0;
						state_q <= S_SQRT;
					end else begin
						step_q <= step_q + 1'b1;
					end
				end
				S_SQRT: begin
					root_q <= {root_q[clfw_pkg::ROOT_W-2:0], sq_ge};
					if (step_q == clfw_pkg::STEP_W'(clfw_pkg::SQRT_LAST)) begin
						step_q  <= '0;
						rem_q   <= '0;
						dvd_q   <= {dot_mag, clfw_pkg::FRAC_SH'(0)};
						q_q     <= '0;
						ovf_q   <= 1'b0;
						state_q <= S_DIV;
					end else begin
						rem_q  <= sq_ge ? (sq_r - sq_t) : sq_r;
						step_q <= step_q + 1'b1;
					end
				end
				S_DIV: begin
					rem_q <= clfw_pkg::REM_W'(dv_ge ? (dv_r - {2'b00, div_d}) : dv_r);
					dvd_q <= {dvd_q[clfw_pkg::DVD_W-2:0], 1'b0};
					q_q   <= {q_q[clfw_pkg::W_W-2:0], dv_ge};
					ovf_q <= ovf_q | q_q[clfw_pkg::W_W-1];
					if (step_q == clfw_pkg::STEP_W'(clfw_pkg::DIV_LAST)) begin
						state_q <= S_FIN;
					end else begin
						step_q <= step_q + 1'b1;
					end
				end
				S_FIN: begin
					w_q[corner_q] <= wval;
					step_q <= '0;
					if (corner_q == 2'd2) begin
						state_q <= S_OUT;
					end else begin
						corner_q <= corner_q + 1'b1;
						state_q  <= S_MUL;
					end
				end
				S_OUT: begin
					if (out_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_corner_rng: assert property (@(posedge clk) disable iff (!arst_n)
		corner_q != 2'd3)
		else $error("corner counter out of range");
	a_mul_step: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MUL) |-> (step_q <= clfw_pkg::STEP_W'(clfw_pkg::MUL_LAST)))
		else $error("multiply step out of range");
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SQRT) |-> !mop_s1.vld)
		else $error("accumulate still pending in square root phase");

endmodule
`default_nettype wire

>>> rtl/clfw_emit.sv
`default_nettype none
module clfw_emit (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  clfw_pkg::wpkt_t in_wpkt,
	clfw_entry_if.source entry
);
	clfw_pkg::wpkt_t cur_q;
	logic busy_q;
	logic [clfw_pkg::CNT_W-1:0] cnt_q;
	logic ovalid_q;
	clfw_pkg::entry_t odata_q;
	logic adv;
	logic last;
	logic [clfw_pkg::IDX_W-1:0] ei;
	logic [clfw_pkg::IDX_W-1:0] ej;
	logic [clfw_pkg::W_W-1:0] w;
	logic [clfw_pkg::W_W-1:0] nw;
	clfw_pkg::entry_t nxt;

	assign in_ready    = !busy_q;
	assign adv         = !ovalid_q || entry.ready;
	assign last        = (cnt_q == clfw_pkg::CNT_W'(clfw_pkg::ENTRIES - 1));
	assign entry.valid = ovalid_q;
	assign entry.data  = odata_q;

	// Edges in the order (b,c), (c,a), (a,b); four entries each.
	always_comb begin
		unique case (cnt_q[3:2])
			2'd0: begin ei = cur_q.ib; ej = cur_q.ic; w = cur_q.w[0]; end
			2'd1: begin ei = cur_q.ic; ej = cur_q.ia; w = cur_q.w[1]; end
			default: begin ei = cur_q.ia; ej = cur_q.ib; w = cur_q.w[2]; end
		endcase
		nw = (w == 32'h8000_0000) ? 32'h7FFF_FFFF : (~w + 1'b1);
		nxt.row_index    = cnt_q[0] ? ej : ei;
		nxt.column_index = (cnt_q[1:0] == 2'd0 || cnt_q[1:0] == 2'd3) ? ej : ei;
		nxt.entry_value  = cnt_q[1] ? w : nw;
		nxt.last_entry   = last;
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			cur_q <= in_wpkt;
		end
		if (adv && busy_q) begin
			odata_q <= nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			cnt_q    <= '0;
			ovalid_q <= 1'b0;
		end else begin
			if (adv) begin
				ovalid_q <= busy_q;
				if (busy_q) begin
					if (last) begin
						cnt_q  <= '0;
						busy_q <= 1'b0;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
			end
			if (in_valid && in_ready) begin
				busy_q <= 1'b1;
			end
		end
	end

	a_cnt_rng: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q < clfw_pkg::CNT_W'(clfw_pkg::ENTRIES))
		else $error("entry counter out of range");
	a_last_frees: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && busy_q && last) |=> (!busy_q && cnt_q == '0))
		else $error("face not released after its last entry");
	a_idle_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		!busy_q |-> (cnt_q == '0))
		else $error("entry counter moved while idle");

endmodule
`default_nettype wire

>>> rtl/cotangent_laplacian_face_weights_top.sv
// The shared weight unit does three corners in turn,
// each with its multiply steps, 67 square-root steps, 83 divide steps and a saturating step.
// Twelve entries then leave one per cycle unless stalled; the next face is already in work.
// Reset: arst_n low clears the queue, the sequencers and the output valid at once.
`default_nettype none
module cotangent_laplacian_face_weights_top (
	input  logic clk,
	input  logic arst_n,
	clfw_face_if.sink face,
	clfw_entry_if.source entry
);
	logic q_valid;
	logic q_ready;
	clfw_pkg::pkt_t q_pkt;
	logic w_valid;
	logic w_ready;
	clfw_pkg::wpkt_t w_pkt;

	clfw_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.face      (face),
		.out_valid (q_valid),
		.out_ready (q_ready),
		.out_pkt   (q_pkt)
	);

	clfw_calc u_calc (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (q_valid),
		.in_ready  (q_ready),
		.in_pkt    (q_pkt),
		.out_valid (w_valid),
		.out_ready (w_ready),
		.out_wpkt  (w_pkt)
	);

	clfw_emit u_emit (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (w_valid),
		.in_ready (w_ready),
		.in_wpkt  (w_pkt),
		.entry    (entry)
	);

endmodule
`default_nettype wire

>>> tb/cotangent_laplacian_face_weights_top_test.sv
`default_nettype none
module cotangent_laplacian_face_weights_top_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LIMIT_CYCLES = 2000000;
	localparam int RANDOM_FACES = 430;
	localparam logic signed [31:0] ONE = 32'sh0001_0000;
	localparam logic signed [31:0] CMAX = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] CMIN = 32'sh8000_0000;

	typedef logic signed [199:0] wide_t;
	typedef logic signed [31:0] coord_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	clfw_face_if face();
	clfw_entry_if entry();

	cotangent_laplacian_face_weights_top u_top (
		.clk(clk),
		.arst_n(arst_n),
		.face(face.sink),
		.entry(entry.source)
	);

	always #4 clk = ~clk;

	clfw_pkg::face_t pending_faces[$];
	clfw_pkg::entry_t expected_entries[$];
	int errors = 0;
	int faces_sent = 0;
	int entries_seen = 0;
	int cycles = 0;
	int send_gap = 0;
	int take_gap = 0;
	int long_hold = 0;
	bit hold_done = 1'b0;
	bit calm = 1'b0;

	task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
		errors++;
		$display("mismatch at entry %0d: %s got %0h expected %0h", entries_seen, what, got, want);
	endtask

	task automatic add_face(input clfw_pkg::face_t f);
		pending_faces = {pending_faces, f};
	endtask

	task automatic add_expected(input clfw_pkg::entry_t e);
		expected_entries = {expected_entries, e};
	endtask

	// Mostly short gaps, a few long ones; none at all while calm.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(20, 80);
	endfunction

	// Half the cotangent at corner p, opposite the edge q-r, in Q16.16.
	function automatic coord_t corner_weight(input coord_t p[3], input coord_t q[3],
			input coord_t r[3]);
		wide_t e1[3];
		wide_t e2[3];
		wide_t dot, cx, cy, cz, sum_sq, root, cand, mag, quo, cap;
		bit neg;
		for (int k = 0; k < 3; k++) begin
			e1[k] = q[k];
			e1[k] = e1[k] - p[k];
			e2[k] = r[k];
			e2[k] = e2[k] - p[k];
		end
		dot = e1[0] * e2[0] + e1[1] * e2[1] + e1[2] * e2[2];
		cx = e1[1] * e2[2] - e1[2] * e2[1];
		cy = e1[2] * e2[0] - e1[0] * e2[2];
		cz = e1[0] * e2[1] - e1[1] * e2[0];
		sum_sq = cx * cx + cy * cy + cz * cz;
		root = '0;
		for (int i = 67; i >= 0; i--) begin
			cand = root | (wide_t'(1) <<< i);
			if (cand * cand <= sum_sq)
				root = cand;
		end
		// A zero cross length is held at one LSB.
		if (root == '0)
			root = wide_t'(1);
		neg = dot < 0;
		mag = neg ? -dot : dot;
		quo = (mag <<< 15) / root;
		cap = neg ? wide_t'(64'h8000_0000) : wide_t'(64'h7FFF_FFFF);
		if (quo > cap)
			quo = cap;
		return neg ? coord_t'(-quo) : coord_t'(quo);
	endfunction

	function automatic coord_t negate_weight(input coord_t w);
		return (w == CMIN) ? CMAX : -w;
	endfunction

	task automatic predict_face_entries(input clfw_pkg::face_t f);
		coord_t pa[3], pb[3], pc[3], w[3], nw;
		logic [15:0] ei[3], ej[3];
		clfw_pkg::entry_t e;
		pa = '{f.a_x, f.a_y, f.a_z};
		pb = '{f.b_x, f.b_y, f.b_z};
		pc = '{f.c_x, f.c_y, f.c_z};
		w[0] = corner_weight(pa, pb, pc);
		w[1] = corner_weight(pb, pc, pa);
		w[2] = corner_weight(pc, pa, pb);
		ei = '{f.vertex_b_index, f.vertex_c_index, f.vertex_a_index};
		ej = '{f.vertex_c_index, f.vertex_a_index, f.vertex_b_index};
		for (int k = 0; k < 3; k++) begin
			nw = negate_weight(w[k]);
			e = '{ei[k], ej[k], nw, 1'b0};
			add_expected(e);
			e = '{ej[k], ei[k], nw, 1'b0};
			add_expected(e);
			e = '{ei[k], ei[k], w[k], 1'b0};
			add_expected(e);
			e = '{ej[k], ej[k], w[k], k == 2};
			add_expected(e);
		end
	endtask

	function automatic clfw_pkg::face_t make_face(input int ia, input int ib,
			input int ic, input coord_t ax, input coord_t ay, input coord_t az,
			input coord_t bx, input coord_t by, input coord_t bz,
			input coord_t cx, input coord_t cy, input coord_t cz);
		clfw_pkg::face_t f;
		f = '{16'(ia), 16'(ib), 16'(ic), ax, ay, az, bx, by, bz, cx, cy, cz};
		return f;
	endfunction

	function automatic clfw_pkg::face_t random_face();
		clfw_pkg::face_t f;
		logic [351:0] raw;
		int scale;
		raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
			$urandom, $urandom, $urandom, $urandom};
		f = raw[335:0];
		// Most faces are mesh-like triangles of modest size; the rest are raw bits.
		if ($urandom_range(0, 3) != 0) begin
			scale = $urandom_range(4, 24);
			f.a_x = $signed(f.a_x) >>> scale;
			f.a_y = $signed(f.a_y) >>> scale;
			f.a_z = $signed(f.a_z) >>> scale;
			f.b_x = f.a_x + ($signed(f.b_x) >>> scale);
			f.b_y = f.a_y + ($signed(f.b_y) >>> scale);
			f.b_z = f.a_z + ($signed(f.b_z) >>> scale);
			f.c_x = f.a_x + ($signed(f.c_x) >>> scale);
			f.c_y = f.a_y + ($signed(f.c_y) >>> scale);
			f.c_z = f.a_z + ($signed(f.c_z) >>> scale);
			if ($urandom_range(0, 9) == 0) begin
				f.c_x = f.b_x;
				f.c_y = f.b_y;
				f.c_z = f.b_z;
			end
		end
		return f;
	endfunction

	// Sender: a request stays up until it is taken.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			face.valid <= 1'b0;
			send_gap <= 0;
		end else begin
			if (face.valid && face.ready) begin
				predict_face_entries(face.data);
				faces_sent++;
			end
			if (face.valid && !face.ready) begin
				face.valid <= 1'b1;
			end else if (send_gap > 0) begin
				send_gap <= send_gap - 1;
				face.valid <= 1'b0;
			end else if (pending_faces.size() > 0) begin
				face.valid <= 1'b1;
				face.data <= pending_faces.pop_front();
				send_gap <= pick_gap();
			end else begin
				face.valid <= 1'b0;
			end
		end
	end

	// Receiver and checker.
	always @(posedge clk or negedge arst_n) begin
		clfw_pkg::entry_t want;
		if (!arst_n) begin
			entry.ready <= 1'b0;
			take_gap <= 0;
			long_hold <= 0;
		end else begin
			if (entry.valid && entry.ready) begin
				if (expected_entries.size() == 0) begin
					report("unexpected entry", 64'(entry.data), 64'(0));
				end else begin
					want = expected_entries.pop_front();
					if (entry.data.row_index !== want.row_index)
						report("row_index", 64'(entry.data.row_index), 64'(want.row_index));
					if (entry.data.column_index !== want.column_index)
						report("column_index", 64'(entry.data.column_index),
							64'(want.column_index));
					if (entry.data.entry_value !== want.entry_value)
						report("entry_value", 64'(entry.data.entry_value),
							64'(want.entry_value));
					if (entry.data.last_entry !== want.last_entry)
						report("last_entry", 64'(entry.data.last_entry), 64'(want.last_entry));
				end
				entries_seen++;
			end
			if (!hold_done && faces_sent == 60) begin
				hold_done <= 1'b1;
				long_hold <= 4000;
				entry.ready <= 1'b0;
			end else if (long_hold > 0) begin
				long_hold <= long_hold - 1;
				entry.ready <= 1'b0;
			end else if (take_gap > 0) begin
				take_gap <= take_gap - 1;
				entry.ready <= 1'b0;
			end else begin
				entry.ready <= 1'b1;
				take_gap <= pick_gap();
			end
			if (entries_seen % 600 == 599)
				calm <= ~calm;
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT_CYCLES) begin
			$display("timeout after %0d cycles", cycles);
			$display("DONE: errors detected");
			$finish;
		end
	end

	task automatic drain_all();
		while (pending_faces.size() > 0 || face.valid || expected_entries.size() > 0)
			@(posedge clk);
	endtask

	initial begin
		face.valid = 1'b0;
		face.data = '0;
		entry.ready = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// All corners at one point: every weight is zero.
		add_face(make_face(0, 1, 2, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		// Right angle at a.
		add_face(make_face(3, 4, 5, 0, 0, 0, ONE, 0, 0, 0, ONE, 0));
		// Equilateral-ish and obtuse shapes.
		add_face(make_face(10, 11, 12, 0, 0, 0, 2 * ONE, 0, 0, ONE, ONE * 3, 0));
		add_face(make_face(7, 8, 9, 0, 0, 0, 8 * ONE, 0, 0, 4 * ONE, ONE / 8, ONE));
		// Collinear with a in the middle: negative saturation and the negation clamp.
		add_face(make_face(13, 14, 15, 0, 0, 0, -ONE, 0, 0, ONE, 0, 0));
		// Repeated corner b = c.
		add_face(make_face(16, 17, 17, 0, 0, 0, ONE, ONE, ONE, ONE, ONE, ONE));
		// Repeated indices with a genuine triangle.
		add_face(make_face(5, 5, 5, ONE, 0, -ONE, 0, ONE, 0, -ONE, 0, ONE));
		// Coordinate and index extremes.
		add_face(make_face(16'hFFFF, 0, 16'h8000,
			CMAX, CMAX, CMAX, CMIN, CMIN, CMIN, CMAX, CMIN, CMAX));
		add_face(make_face(16'h0000, 16'hFFFF, 16'h7FFF,
			CMIN, CMAX, 0, CMAX, CMIN, 0, 0, 0, CMAX));
		add_face(make_face(1, 2, 3, CMAX, 0, 0, CMIN, 0, 0, 0, CMAX, CMIN));
		// Tiny triangle, one LSB across.
		add_face(make_face(20, 21, 22, 0, 0, 0, 1, 0, 0, 0, 1, 0));
		// Sliver: a huge cotangent that saturates positive.
		add_face(make_face(23, 24, 25, 0, 0, 0, CMAX, 0, 0, CMAX, 1, 0));
		drain_all();

		for (int i = 0; i < RANDOM_FACES; i++) begin
			add_face(random_face());
			// Now and then the sender stops until everything has come back.
			if (i % 150 == 149)
				drain_all();
		end
		drain_all();
		repeat (600) @(posedge clk);

		$display("Sent %0d faces and checked %0d matrix entries, with degenerate,", faces_sent,
			entries_seen);
		$display("saturating and extreme-coordinate triangles under random back-pressure.");
		if (errors == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("%0d mismatches", errors);
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
`default_nettype wire
